// File: hdl/gbp_pkg.sv
// Shared types and constants for the gap buffer page block.
// Used by gbp_ctrl, gbp_datapath and the top level gap_buffer_page.
package gbp_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int POS_W      = 13;
    localparam int ADDR_W     = $clog2(PAGE_BYTES);

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [7:0]        byte_t;

    localparam pos_t PAGE_POS = pos_t'(PAGE_BYTES);

    typedef enum logic [1:0] {
        MODE_FWD    = 2'd0,
        MODE_BACK   = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_DELETE = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_WRITE = 1'b1
    } state_t;

    typedef struct packed {
        logic start_move;
        logic apply;
        logic finish_move;
    } dp_cmd_t;

    typedef struct packed {
        logic op_ok;
        logic op_is_move;
    } dp_status_t;

endpackage

// File: hdl/gbp_ctrl.sv
// Controller state machine for the gap buffer page block.
// Depends on gbp_pkg; drives the command struct of gbp_datapath.
module gbp_ctrl
    import gbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && status.op_is_move && status.op_ok)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        done_next = 1'b0;
        busy      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (status.op_is_move && status.op_ok)
                    begin
                        cmd.start_move = 1'b1;
                    end
                    else
                    begin
                        cmd.apply = 1'b1;
                        done_next = 1'b1;
                    end
                end
            end
            ST_WRITE:
            begin
                busy            = 1'b1;
                cmd.finish_move = 1'b1;
                done_next       = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// File: hdl/gbp_datapath.sv
// Datapath of the gap buffer page block: byte store, gap pointers, count and result.
// Depends on gbp_pkg; commanded by gbp_ctrl.
module gbp_datapath
    import gbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] mode,
    input  byte_t      byte_value,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output pos_t       gap_start_pos,
    output pos_t       gap_end_pos,
    output pos_t       text_count,
    output byte_t      moved_byte,
    output logic       op_error
);

    byte_t store_mem [PAGE_BYTES];
    byte_t rd_data_reg;

    pos_t  gap_begin_reg;
    pos_t  gap_begin_next;
    pos_t  gap_finish_reg;
    pos_t  gap_finish_next;
    pos_t  held_count_reg;
    pos_t  held_count_next;
    mode_t mode_reg;
    byte_t moved_reg;
    byte_t moved_next;
    logic  error_reg;
    logic  error_next;

    mode_t mode_in;
    pos_t  begin_dec;
    pos_t  finish_dec;
    logic  fwd_ok;
    logic  back_ok;
    logic  ins_ok;
    logic  del_ok;
    logic  wr_en;
    addr_t wr_addr;
    byte_t wr_data;
    addr_t rd_addr;

    assign mode_in    = mode_t'(mode);
    assign begin_dec  = gap_begin_reg - 1'b1;
    assign finish_dec = gap_finish_reg - 1'b1;

    assign fwd_ok  = (gap_finish_reg < PAGE_POS) && (gap_begin_reg < PAGE_POS);
    assign back_ok = (gap_begin_reg != '0) && (gap_finish_reg != '0);
    assign ins_ok  = (held_count_reg < PAGE_POS) && (gap_begin_reg < gap_finish_reg)
                     && (gap_begin_reg < PAGE_POS);
    assign del_ok  = (gap_begin_reg != '0);

    always_comb
    begin
        status.op_is_move = 1'b0;
        status.op_ok      = 1'b0;
        case (mode_in)
            MODE_FWD:
            begin
                status.op_is_move = 1'b1;
                status.op_ok      = fwd_ok;
            end
            MODE_BACK:
            begin
                status.op_is_move = 1'b1;
                status.op_ok      = back_ok;
            end
            MODE_INSERT:
            begin
                status.op_ok = ins_ok;
            end
            MODE_DELETE:
            begin
                status.op_ok = del_ok;
            end
            default:
            begin
                status.op_ok = 1'b0;
            end
        endcase
    end

    assign rd_addr = (mode_in == MODE_FWD) ? gap_finish_reg[ADDR_W-1:0]
                                           : begin_dec[ADDR_W-1:0];

    always_comb
    begin
        gap_begin_next  = gap_begin_reg;
        gap_finish_next = gap_finish_reg;
        held_count_next = held_count_reg;
        moved_next      = moved_reg;
        error_next      = error_reg;
        wr_en           = 1'b0;
        wr_addr         = gap_begin_reg[ADDR_W-1:0];
        wr_data         = byte_value;
        if (cmd.apply)
        begin
            moved_next = '0;
            error_next = 1'b1;
            if (mode_in == MODE_INSERT && ins_ok)
            begin
                wr_en           = 1'b1;
                gap_begin_next  = gap_begin_reg + 1'b1;
                held_count_next = held_count_reg + 1'b1;
                moved_next      = byte_value;
                error_next      = 1'b0;
            end
            else if (mode_in == MODE_DELETE && del_ok)
            begin
                gap_begin_next = begin_dec;
                if (held_count_reg != '0)
                begin
                    held_count_next = held_count_reg - 1'b1;
                end
                error_next = 1'b0;
            end
        end
        else if (cmd.finish_move)
        begin
            wr_en      = 1'b1;
            wr_data    = rd_data_reg;
            moved_next = rd_data_reg;
            error_next = 1'b0;
            if (mode_reg == MODE_FWD)
            begin
                wr_addr         = gap_begin_reg[ADDR_W-1:0];
                gap_begin_next  = gap_begin_reg + 1'b1;
                gap_finish_next = gap_finish_reg + 1'b1;
            end
            else
            begin
                wr_addr         = finish_dec[ADDR_W-1:0];
                gap_begin_next  = begin_dec;
                gap_finish_next = finish_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.start_move)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_move)
        begin
            mode_reg <= mode_in;
        end
        moved_reg <= moved_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_begin_reg  <= '0;
            gap_finish_reg <= PAGE_POS;
            held_count_reg <= '0;
            error_reg      <= 1'b0;
        end
        else
        begin
            gap_begin_reg  <= gap_begin_next;
            gap_finish_reg <= gap_finish_next;
            held_count_reg <= held_count_next;
            error_reg      <= error_next;
        end
    end

    assign gap_start_pos = gap_begin_reg;
    assign gap_end_pos   = gap_finish_reg;
    assign text_count    = held_count_reg;
    assign moved_byte    = moved_reg;
    assign op_error      = error_reg;

endmodule

// File: hdl/gap_buffer_page.sv
// Top level of the gap buffer page block: one page of text held as a gap buffer.
// Depends on gbp_pkg and instantiates gbp_ctrl and gbp_datapath.
//
// An operation is taken when start is high and busy is low. Insert, delete and any
// refused operation finish in the cycle they are taken; a gap move first reads one
// byte of the single-port store and then writes it to the other side of the gap.
// The result appears on the cycle after the operation completes, with done high for
// exactly that cycle, and must be captured then because the receiver cannot stall.
// A new operation may be started in the same cycle that a result is shown.
module gap_buffer_page
    import gbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  byte_value,
    output logic        done,
    output logic [12:0] gap_start_pos,
    output logic [12:0] gap_end_pos,
    output logic [12:0] text_count,
    output logic [7:0]  moved_byte,
    output logic        op_error
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gbp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    gbp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .byte_value    (byte_value),
        .cmd           (cmd),
        .status        (status),
        .gap_start_pos (gap_start_pos),
        .gap_end_pos   (gap_end_pos),
        .text_count    (text_count),
        .moved_byte    (moved_byte),
        .op_error      (op_error)
    );

endmodule
